@@ rtl/core/fria_pkg.sv @@
package fria_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned STEP_CNT_W = $clog2(WORD_W);
  localparam int unsigned MODE_W = 3;
  localparam int unsigned FAULT_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [STEP_CNT_W-1:0] step_cnt_t;
  typedef logic [FAULT_W-1:0] fault_t;

  typedef enum logic [MODE_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_ADD   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MOD   = 3'd4,
    OP_EQL   = 3'd5,
    OP_CLEAR = 3'd6
  } op_t;

  localparam fault_t FLT_OK         = 2'd0;
  localparam fault_t FLT_DIV_ZERO   = 2'd1;
  localparam fault_t FLT_MOD_NONPOS = 2'd2;
  localparam fault_t FLT_UNUSED     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN,
    ST_WB
  } state_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } unit_status_t;

endpackage

@@ rtl/core/fria_ifs.sv @@
interface fria_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [1:0]          dest_reg;
  logic                use_register;
  logic [1:0]          source_reg;
  logic signed [63:0]  immediate;

  modport source (
    output valid, mode, dest_reg, use_register, source_reg, immediate,
    input  ready
  );
  modport sink (
    input  valid, mode, dest_reg, use_register, source_reg, immediate,
    output ready
  );
endinterface

interface fria_out_if;
  logic                valid;
  logic                ready;
  logic signed [63:0]  result;
  logic [1:0]          fault;

  modport source (
    output valid, result, fault,
    input  ready
  );
  modport sink (
    input  valid, result, fault,
    output ready
  );
endinterface

@@ rtl/core/fria_mul.sv @@
module fria_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  fria_pkg::word_t a,
  input  fria_pkg::word_t b,
  output logic           done,
  output fria_pkg::word_t product
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  fria_pkg::step_cnt_t   cnt_r, cnt_nxt;
  fria_pkg::word_t       acc_r, acc_nxt;
  fria_pkg::word_t       mcand_r, mcand_nxt;
  fria_pkg::word_t       mplier_r, mplier_nxt;

  localparam fria_pkg::step_cnt_t LAST_STEP = fria_pkg::step_cnt_t'(fria_pkg::WORD_W - 1);

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mcand_nxt  = a;
      mplier_nxt = b;
    end else if (busy_r) begin
      // add one partial product per cycle
      acc_nxt    = mplier_r[0] ? (acc_r + mcand_r) : acc_r;
      mcand_nxt  = {mcand_r[fria_pkg::WORD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[fria_pkg::WORD_W-1:1]};
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

@@ rtl/core/fria_div.sv @@
module fria_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  fria_pkg::word_t a,
  input  fria_pkg::word_t b,
  output logic            done,
  output fria_pkg::word_t quotient,
  output fria_pkg::word_t remainder
);

  localparam int unsigned W = fria_pkg::WORD_W;
  localparam fria_pkg::step_cnt_t LAST_STEP = fria_pkg::step_cnt_t'(W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  fria_pkg::step_cnt_t   cnt_r, cnt_nxt;
  fria_pkg::word_t       quo_r, quo_nxt;
  fria_pkg::word_t       rem_r, rem_nxt;
  fria_pkg::word_t       dvs_r, dvs_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;
  logic [W:0]            shifted;
  logic [W:0]            diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = '0;
      quo_nxt   = a[W-1] ? (~a + 1'b1) : a;
      dvs_nxt   = b[W-1] ? (~b + 1'b1) : b;
      neg_q_nxt = a[W-1] ^ b[W-1];
      neg_r_nxt = a[W-1];
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (~quo_r + 1'b1) : quo_r;
  assign remainder = neg_r_r ? (~rem_r + 1'b1) : rem_r;

endmodule

@@ rtl/core/four_register_integer_alu_unit.sv @@
// Channel  Dir  Handshake      Payload
// in_ch    in   valid / ready  mode, dest_reg, use_register, source_reg, immediate
// out_ch   out  valid / ready  result, fault
//
// Multiply, divide and remainder run in the serial units: the shift-add multiplier
// and the restoring divider retire one bit a cycle; no item is taken meanwhile.
// Load, add, equality, clear, faults and the unused opcode skip the serial units.
// A held result in the output register does not block the next item; a second
// result waits in the write-back state until out_ch takes the first.
// Reset (rst_n low, synchronous) makes all four registers read 0, empties out_ch.
module four_register_integer_alu_unit (
  input  logic              clk,
  input  logic              rst_n,
  fria_in_if.sink           in_ch,
  fria_out_if.source        out_ch
);

  localparam int unsigned W = fria_pkg::WORD_W;

  fria_pkg::state_t         state_r, state_nxt;

  fria_pkg::word_t          mem [fria_pkg::NUM_REGS];
  logic [fria_pkg::NUM_REGS-1:0] vld_r;

  fria_pkg::word_t          mem_a_r, mem_b_r, imm_r;
  logic                     vld_a_r, vld_b_r;
  logic                     b_from_reg_r;
  logic [fria_pkg::MODE_W-1:0] mode_r;
  fria_pkg::reg_idx_t       dest_r;

  fria_pkg::word_t          op_a, op_b;

  fria_pkg::word_t          res_r, res_nxt;
  fria_pkg::fault_t         fault_r, fault_nxt;
  logic                     res_ld;

  logic                     wr_en;
  fria_pkg::reg_idx_t       wr_addr;
  fria_pkg::word_t          wr_data;
  logic                     clr_all;

  logic                     mul_start, div_start;
  fria_pkg::unit_status_t   unit_st;
  fria_pkg::word_t          mul_product, div_quo, div_rem;

  logic                     accept;
  logic                     out_valid_r;
  fria_pkg::word_t          out_result_r;
  fria_pkg::fault_t         out_fault_r;
  logic                     out_free;
  logic                     serial_op;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign op_a = vld_a_r ? mem_a_r : '0;
  assign op_b = b_from_reg_r ? (vld_b_r ? mem_b_r : '0) : imm_r;

  always_comb begin
    unique case (mode_r)
      fria_pkg::OP_MUL: serial_op = 1'b1;
      fria_pkg::OP_DIV: serial_op = (op_b != '0);
      fria_pkg::OP_MOD: serial_op = (op_b != '0) && !op_b[W-1];
      default:          serial_op = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fria_pkg::ST_IDLE: if (in_ch.valid) state_nxt = fria_pkg::ST_EXEC;
      fria_pkg::ST_EXEC: state_nxt = serial_op ? fria_pkg::ST_RUN : fria_pkg::ST_WB;
      fria_pkg::ST_RUN:  if (unit_st.mul_done || unit_st.div_done) state_nxt = fria_pkg::ST_WB;
      fria_pkg::ST_WB:   if (out_free) state_nxt = fria_pkg::ST_IDLE;
      default:           state_nxt = fria_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ch.ready = (state_r == fria_pkg::ST_IDLE);
    mul_start   = 1'b0;
    div_start   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = dest_r;
    wr_data     = '0;
    clr_all     = 1'b0;
    res_ld      = 1'b0;
    res_nxt     = op_a;
    fault_nxt   = fria_pkg::FLT_OK;
    unique case (state_r)
      fria_pkg::ST_EXEC: begin
        res_ld = !serial_op;
        unique case (mode_r)
          fria_pkg::OP_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = imm_r;
            res_nxt = imm_r;
          end
          fria_pkg::OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = op_a + op_b;
            res_nxt = wr_data;
          end
          fria_pkg::OP_MUL: mul_start = 1'b1;
          fria_pkg::OP_DIV: begin
            div_start = serial_op;
            if (!serial_op) fault_nxt = fria_pkg::FLT_DIV_ZERO;
          end
          fria_pkg::OP_MOD: begin
            div_start = serial_op;
            if (!serial_op) fault_nxt = fria_pkg::FLT_MOD_NONPOS;
          end
          fria_pkg::OP_EQL: begin
            wr_en   = 1'b1;
            wr_data = (op_a == op_b) ? fria_pkg::word_t'(1) : '0;
            res_nxt = wr_data;
          end
          fria_pkg::OP_CLEAR: begin
            clr_all = 1'b1;
            res_nxt = '0;
          end
          default: ;
        endcase
      end
      fria_pkg::ST_RUN: begin
        if (unit_st.mul_done || unit_st.div_done) begin
          wr_en   = 1'b1;
          res_ld  = 1'b1;
          wr_data = unit_st.mul_done ? mul_product
                  : ((mode_r == fria_pkg::OP_DIV) ? div_quo : div_rem);
          res_nxt = wr_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fria_pkg::ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (state_r == fria_pkg::ST_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_a_r      <= mem[in_ch.dest_reg];
      mem_b_r      <= mem[in_ch.source_reg];
      vld_a_r      <= vld_r[in_ch.dest_reg];
      vld_b_r      <= vld_r[in_ch.source_reg];
      imm_r        <= in_ch.immediate;
      mode_r       <= in_ch.mode;
      dest_r       <= in_ch.dest_reg;
      b_from_reg_r <= in_ch.use_register && (in_ch.mode != fria_pkg::OP_LOAD);
    end
    if (res_ld) begin
      res_r   <= res_nxt;
      fault_r <= fault_nxt;
    end
    if (state_r == fria_pkg::ST_WB && out_free) begin
      out_result_r <= res_r;
      out_fault_r  <= fault_r;
    end
  end

  fria_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (op_a),
    .b       (op_b),
    .done    (unit_st.mul_done),
    .product (mul_product)
  );

  fria_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .a         (op_a),
    .b         (op_b),
    .done      (unit_st.div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;
  assign out_ch.fault  = out_fault_r;

endmodule

@@ rtl/core/fria_chk.sv @@
module fria_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic [1:0]  out_fault
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fault != fria_pkg::FLT_UNUSED)
    else $error("unused fault code on output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_fault))
    else $error("stalled result dropped or changed");

endmodule

bind four_register_integer_alu_unit fria_chk u_fria_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result),
  .out_fault  (out_ch.fault)
);

@@ tb/tb_four_register_integer_alu_unit.sv @@
`timescale 1ns / 1ps

module tb_four_register_integer_alu_unit;

  localparam int CLK_PERIOD = 12;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 360;
  localparam int PRESSURE_ITEMS = 60;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [fria_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam fria_pkg::word_t W_MIN = 64'h8000_0000_0000_0000;
  localparam fria_pkg::word_t W_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam fria_pkg::word_t W_ONES = 64'hffff_ffff_ffff_ffff;
  localparam fria_pkg::word_t W_ZERO = 64'd0;
  localparam fria_pkg::word_t W_ONE = 64'd1;

  typedef struct packed {
    logic [fria_pkg::MODE_W-1:0] mode;
    fria_pkg::reg_idx_t          dest;
    logic                        use_reg;
    fria_pkg::reg_idx_t          src;
    fria_pkg::word_t             imm;
  } alu_item_t;

  typedef struct packed {
    fria_pkg::word_t  res;
    fria_pkg::fault_t flt;
  } alu_result_t;

  typedef struct packed {
    alu_item_t        item;
    logic             known;
    fria_pkg::word_t  res;
    fria_pkg::fault_t flt;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;

  fria_in_if  in_ch ();
  fria_out_if out_ch ();

  four_register_integer_alu_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  fria_pkg::word_t regs_mirror [fria_pkg::NUM_REGS];
  alu_result_t     pending_results [$];
  vector_t         directed_rows [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int hold_left = 0;

  function automatic fria_pkg::word_t abs_word(input fria_pkg::word_t v);
    return v[fria_pkg::WORD_W-1] ? -v : v;
  endfunction

  function automatic void alu_predict(input alu_item_t it, output fria_pkg::word_t res,
                                      output fria_pkg::fault_t flt);
    fria_pkg::word_t a;
    fria_pkg::word_t b;
    fria_pkg::word_t mag;
    logic            wr;
    a = regs_mirror[it.dest];
    b = it.use_reg ? regs_mirror[it.src] : it.imm;
    res = a;
    flt = fria_pkg::FLT_OK;
    wr = 1'b0;
    case (it.mode)
      fria_pkg::OP_LOAD: begin
        regs_mirror[0] = it.imm;
        res = it.imm;
      end
      fria_pkg::OP_ADD: begin
        res = a + b;
        wr = 1'b1;
      end
      fria_pkg::OP_MUL: begin
        res = a * b;
        wr = 1'b1;
      end
      fria_pkg::OP_DIV: begin
        if (b == W_ZERO) begin
          flt = fria_pkg::FLT_DIV_ZERO;
        end else begin
          mag = abs_word(a) / abs_word(b);
          res = (a[fria_pkg::WORD_W-1] ^ b[fria_pkg::WORD_W-1]) ? -mag : mag;
          wr = 1'b1;
        end
      end
      fria_pkg::OP_MOD: begin
        if (b == W_ZERO || b[fria_pkg::WORD_W-1]) begin
          flt = fria_pkg::FLT_MOD_NONPOS;
        end else begin
          mag = abs_word(a) % abs_word(b);
          res = a[fria_pkg::WORD_W-1] ? -mag : mag;
          wr = 1'b1;
        end
      end
      fria_pkg::OP_EQL: begin
        res = (a == b) ? W_ONE : W_ZERO;
        wr = 1'b1;
      end
      fria_pkg::OP_CLEAR: begin
        for (int i = 0; i < fria_pkg::NUM_REGS; i++) regs_mirror[i] = W_ZERO;
        res = W_ZERO;
      end
      default: ;
    endcase
    if (wr) regs_mirror[it.dest] = res;
  endfunction

  function automatic alu_item_t random_item(input bit fast_only);
    alu_item_t it;
    int pick;
    int v;
    pick = $urandom_range(99);
    if (fast_only) begin
      if (pick < 30) it.mode = fria_pkg::OP_LOAD;
      else if (pick < 60) it.mode = fria_pkg::OP_ADD;
      else if (pick < 85) it.mode = fria_pkg::OP_EQL;
      else if (pick < 90) it.mode = fria_pkg::OP_CLEAR;
      else it.mode = MODE_UNUSED;
    end else begin
      if (pick < 12) it.mode = fria_pkg::OP_LOAD;
      else if (pick < 27) it.mode = fria_pkg::OP_ADD;
      else if (pick < 42) it.mode = fria_pkg::OP_MUL;
      else if (pick < 58) it.mode = fria_pkg::OP_DIV;
      else if (pick < 74) it.mode = fria_pkg::OP_MOD;
      else if (pick < 90) it.mode = fria_pkg::OP_EQL;
      else if (pick < 93) it.mode = fria_pkg::OP_CLEAR;
      else it.mode = MODE_UNUSED;
    end
    it.dest = fria_pkg::reg_idx_t'($urandom_range(fria_pkg::NUM_REGS - 1));
    it.src = fria_pkg::reg_idx_t'($urandom_range(fria_pkg::NUM_REGS - 1));
    it.use_reg = ($urandom_range(99) < 40);
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.imm = {$urandom, $urandom};
    end else if (pick < 70) begin
      v = $urandom_range(18);
      v = v - 9;
      it.imm = fria_pkg::word_t'(longint'(v));
    end else if (pick < 80) begin
      case ($urandom_range(4))
        0: it.imm = W_MIN;
        1: it.imm = W_MAX;
        2: it.imm = W_ONES;
        3: it.imm = W_ZERO;
        default: it.imm = W_ONE;
      endcase
    end else begin
      it.imm = regs_mirror[it.dest];
    end
    return it;
  endfunction

  task automatic row(input logic [fria_pkg::MODE_W-1:0] mode, input int dest,
                     input logic use_reg, input int src, input fria_pkg::word_t imm,
                     input logic known, input fria_pkg::word_t res,
                     input fria_pkg::fault_t flt);
    vector_t r;
    r.item.mode = mode;
    r.item.dest = fria_pkg::reg_idx_t'(dest);
    r.item.use_reg = use_reg;
    r.item.src = fria_pkg::reg_idx_t'(src);
    r.item.imm = imm;
    r.known = known;
    r.res = res;
    r.flt = flt;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(input alu_item_t it, input logic known,
                           input fria_pkg::word_t t_res, input fria_pkg::fault_t t_flt);
    alu_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= it.mode;
    in_ch.dest_reg     <= it.dest;
    in_ch.use_register <= it.use_reg;
    in_ch.source_reg   <= it.src;
    in_ch.immediate    <= it.imm;
    do @(posedge clk); while (!in_ch.ready);
    alu_predict(it, want.res, want.flt);
    if (known) begin
      want.res = t_res;
      want.flt = t_flt;
    end
    pending_results.insert(pending_results.size(), want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic bit hold_left_active();
    if (hold_left > 0) begin
      hold_left--;
      return 1'b1;
    end
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left_active()) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, result %h fault %0d", $time, out_ch.result,
                 out_ch.fault);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_ch.result !== want.res) begin
          $display("%0t: result mismatch, expected %h actual %h", $time, want.res,
                   out_ch.result);
          mismatch_count++;
        end
        if (out_ch.fault !== want.flt) begin
          $display("%0t: fault mismatch, expected %0d actual %0d", $time, want.flt,
                   out_ch.fault);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = fria_pkg::OP_LOAD;
    in_ch.dest_reg = '0;
    in_ch.use_register = 1'b0;
    in_ch.source_reg = '0;
    in_ch.immediate = '0;
    for (int i = 0; i < fria_pkg::NUM_REGS; i++) regs_mirror[i] = W_ZERO;

    row(fria_pkg::OP_EQL,   3, 1'b0, 0, W_ZERO, 1'b1, W_ONE,  fria_pkg::FLT_OK);
    row(fria_pkg::OP_LOAD,  0, 1'b0, 0, W_MAX,  1'b1, W_MAX,  fria_pkg::FLT_OK);
    row(fria_pkg::OP_LOAD,  3, 1'b1, 2, W_MIN,  1'b1, W_MIN,  fria_pkg::FLT_OK);
    row(fria_pkg::OP_DIV,   0, 1'b0, 0, W_ONES, 1'b1, W_MIN,  fria_pkg::FLT_OK);
    row(fria_pkg::OP_DIV,   0, 1'b0, 0, W_ZERO, 1'b1, W_MIN,  fria_pkg::FLT_DIV_ZERO);
    row(fria_pkg::OP_MOD,   0, 1'b0, 0, W_ZERO, 1'b1, W_MIN,  fria_pkg::FLT_MOD_NONPOS);
    row(fria_pkg::OP_MOD,   0, 1'b0, 0, -64'd5, 1'b1, W_MIN,  fria_pkg::FLT_MOD_NONPOS);
    row(fria_pkg::OP_MOD,   0, 1'b0, 0, 64'd7,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_ADD,   1, 1'b1, 0, W_MAX,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_MUL,   1, 1'b0, 3, W_MAX,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_DIV,   1, 1'b1, 2, W_ONE,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_EQL,   2, 1'b1, 3, W_ZERO, 1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(MODE_UNUSED,        1, 1'b0, 0, W_MIN,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_CLEAR, 2, 1'b1, 1, W_ONES, 1'b1, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_ADD,   2, 1'b0, 0, W_ONES, 1'b1, W_ONES, fria_pkg::FLT_OK);
    row(fria_pkg::OP_MUL,   2, 1'b0, 0, W_MIN,  1'b1, W_MIN,  fria_pkg::FLT_OK);
    row(fria_pkg::OP_DIV,   2, 1'b0, 0, 64'd3,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_LOAD,  1, 1'b0, 0, W_ONES, 1'b1, W_ONES, fria_pkg::FLT_OK);
    row(fria_pkg::OP_MOD,   3, 1'b1, 0, W_ONE,  1'b1, W_ZERO, fria_pkg::FLT_MOD_NONPOS);
    row(fria_pkg::OP_DIV,   3, 1'b1, 3, W_ONE,  1'b1, W_ZERO, fria_pkg::FLT_DIV_ZERO);
    row(fria_pkg::OP_ADD,   0, 1'b0, 0, W_ONE,  1'b1, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_EQL,   0, 1'b0, 0, W_ZERO, 1'b1, W_ONE,  fria_pkg::FLT_OK);
    row(MODE_UNUSED,        3, 1'b1, 1, W_MAX,  1'b0, W_ZERO, fria_pkg::FLT_OK);
    row(fria_pkg::OP_MOD,   2, 1'b1, 0, W_ZERO, 1'b0, W_ZERO, fria_pkg::FLT_OK);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].res,
                directed_rows[i].flt);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(random_item(1'b0), 1'b0, W_ZERO, fria_pkg::FLT_OK);
      wait_drained();
    end

    // long receiver hold-off while fast items keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_requests++;
    @(negedge clk);
    repeat (PRESSURE_ITEMS) send_item(random_item(1'b1), 1'b0, W_ZERO, fria_pkg::FLT_OK);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d directed), checked %0d results, %0d mismatches.",
             items_sent, directed_rows.size(), results_checked, mismatch_count);
    $display("Idle patterns: none, sender, receiver, both, plus a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fria_pkg.sv
rtl/core/fria_ifs.sv
rtl/core/fria_mul.sv
rtl/core/fria_div.sv
rtl/core/four_register_integer_alu_unit.sv
rtl/core/fria_chk.sv
tb/tb_four_register_integer_alu_unit.sv
